// File: sv/i2c_master_bit_sequencer_defines.svh
// ----------------------------------------------------------------------------
// i2c master bit sequencer assertion macros
// shared property wrappers, all clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// checked only outside reset
`define I2CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define I2CBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cbs_pkg
// types and constants shared by the i2c master bit sequencer
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned DELAY_W       = 20;
  localparam int unsigned TDATA_W       = 16;

  // command codes
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_WAITACK = 3'd4,
    CMD_READ    = 3'd5
  } cmd_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TICKS_PER_UNIT = 1'b0,
    REG_ACK_TIMEOUT    = 1'b1
  } reg_idx_e;

  localparam logic [15:0] TICKS_RESET   = 16'd1;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [7:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [2:0]         phase;
    logic [3:0]         bit_cnt;
    logic [7:0]         shift;
    logic [DELAY_W-1:0] delay;
    logic [7:0]         poll;
    logic               scl;
    logic               sda;
    logic               drv;
    logic               ack_flag;
    logic               ack_choice;
    logic [7:0]         rx;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{
    cmd:        CMD_NONE,
    phase:      3'd0,
    bit_cnt:    4'd0,
    shift:      8'd0,
    delay:      '0,
    poll:       8'd0,
    scl:        1'b0,
    sda:        1'b0,
    drv:        1'b1,
    ack_flag:   1'b0,
    ack_choice: 1'b0,
    rx:         8'd0
  };

endpackage

// File: sv/i2cbs_step.sv
// ----------------------------------------------------------------------------
// i2cbs_step
// next-state logic for one clock tick of the sequencer
// ----------------------------------------------------------------------------
module i2cbs_step import i2cbs_pkg::*; (
  input  seq_state_t cur_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  output seq_state_t nxt_o,
  output logic       done_o
);

  logic [15:0]        tpu;
  logic [DELAY_W-1:0] wait1, wait2, wait4;
  seq_state_t         s;
  logic               done;
  logic               run;

  assign tpu   = (cfg_i.ticks_per_unit == 16'd0) ? 16'd1 : cfg_i.ticks_per_unit;
  assign wait1 = {4'd0, tpu};
  assign wait2 = {3'd0, tpu, 1'b0};
  assign wait4 = {2'd0, tpu, 2'b00};

  always_comb begin
    s    = cur_i;
    done = 1'b0;
    run  = 1'b0;

    if (cur_i.cmd == CMD_NONE) begin
      unique case (cmd_e'(item_i.cmd)) inside
        CMD_START, CMD_STOP, CMD_WRITE, CMD_WAITACK, CMD_READ: begin
          s.cmd   = cmd_e'(item_i.cmd);
          s.phase = 3'd0;
          if (cmd_e'(item_i.cmd) == CMD_WRITE) s.shift = item_i.tx_byte;
          if (cmd_e'(item_i.cmd) == CMD_READ) s.ack_choice = item_i.send_ack;
          run = 1'b1;
        end
        default: ;
      endcase
    end else begin
      if (cur_i.delay != '0) s.delay = cur_i.delay - DELAY_W'(1);
      run = (s.delay == '0);
    end

    if (run) begin
      unique case (s.cmd)
        CMD_START: begin
          if (s.phase == 3'd0) begin
            s.scl = 1'b1; s.sda = 1'b1; s.drv = 1'b1;
            s.delay = wait4; s.phase = 3'd1;
          end else if (s.phase == 3'd1) begin
            s.scl = 1'b1; s.sda = 1'b0; s.drv = 1'b1;
            s.delay = wait4; s.phase = 3'd2;
          end else begin
            s.scl = 1'b0; s.sda = 1'b0; s.drv = 1'b1;
            s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
          end
        end
        CMD_STOP: begin
          if (s.phase == 3'd0) begin
            s.scl = 1'b0; s.sda = 1'b0; s.drv = 1'b1;
            s.delay = wait4; s.phase = 3'd1;
          end else if (s.phase == 3'd1) begin
            s.scl = 1'b1; s.sda = 1'b1; s.drv = 1'b1;
            s.delay = wait4; s.phase = 3'd2;
          end else begin
            s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (s.phase == 3'd1) begin
            s.scl = 1'b1; s.delay = wait2; s.phase = 3'd2;
          end else if (s.phase == 3'd2) begin
            s.scl = 1'b0; s.bit_cnt = s.bit_cnt + 4'd1;
            s.delay = wait2; s.phase = 3'd3;
          end else if (s.phase != 3'd0 && s.bit_cnt >= 4'(BITS_PER_BYTE)) begin
            s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
          end else begin
            // shift out the msb, scl low while data settles
            if (s.phase == 3'd0) s.bit_cnt = 4'd0;
            s.scl   = 1'b0;
            s.sda   = s.shift[BITS_PER_BYTE-1];
            s.drv   = 1'b1;
            s.shift = {s.shift[BITS_PER_BYTE-2:0], 1'b0};
            s.delay = wait2; s.phase = 3'd1;
          end
        end
        CMD_WAITACK: begin
          if (s.phase == 3'd0) begin
            s.ack_flag = 1'b0; s.poll = 8'd0;
            s.sda = 1'b1; s.drv = 1'b0;
            s.delay = wait1; s.phase = 3'd1;
          end else if (s.phase == 3'd1) begin
            s.scl = 1'b1; s.delay = wait1; s.phase = 3'd2;
          end else if (s.phase == 3'd2) begin
            if (!item_i.sda_in) begin
              s.scl = 1'b0;
              s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
            end else if (s.poll >= cfg_i.ack_timeout) begin
              // timed out: flag and run a stop
              s.ack_flag = 1'b1;
              s.scl = 1'b0; s.sda = 1'b0; s.drv = 1'b1;
              s.delay = wait4; s.phase = 3'd3;
            end else begin
              s.poll = s.poll + 8'd1;
              s.delay = wait1; s.phase = 3'd2;
            end
          end else if (s.phase == 3'd3) begin
            s.scl = 1'b1; s.sda = 1'b1; s.drv = 1'b1;
            s.delay = wait4; s.phase = 3'd4;
          end else begin
            s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
          end
        end
        CMD_READ: begin
          if (s.phase == 3'd0) begin
            s.shift = 8'd0; s.bit_cnt = 4'd0;
            s.scl = 1'b0; s.drv = 1'b0;
            s.delay = wait2; s.phase = 3'd1;
          end else if (s.phase == 3'd1) begin
            s.scl = 1'b1;
            s.shift = {s.shift[BITS_PER_BYTE-2:0], item_i.sda_in};
            s.bit_cnt = s.bit_cnt + 4'd1;
            s.delay = wait1; s.phase = 3'd2;
          end else if (s.phase == 3'd2) begin
            if (s.bit_cnt < 4'(BITS_PER_BYTE)) begin
              s.scl = 1'b0; s.delay = wait2; s.phase = 3'd1;
            end else begin
              s.scl = 1'b0; s.sda = !s.ack_choice; s.drv = 1'b1;
              s.delay = wait2; s.phase = 3'd3;
            end
          end else if (s.phase == 3'd3) begin
            s.scl = 1'b1; s.delay = wait2; s.phase = 3'd4;
          end else begin
            s.scl = 1'b0; s.rx = s.shift;
            s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
          end
        end
        default: begin
          s.cmd = CMD_NONE; s.phase = 3'd0; s.delay = '0; done = 1'b1;
        end
      endcase
    end
  end

  assign nxt_o  = s;
  assign done_o = done;

endmodule

// File: sv/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// i2c master line sequencer, one input request per clock tick of the bus timer
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  cmd, tx_byte, send_ack, sda_in
// m_axis    out  m_axis_tvalid/m_axis_tready  pins, busy, done, rx_byte, ack_fail
// cfg       in   cfg_we_i (no wait)           ticks_per_unit, ack_timeout
//
// the sequencer state is updated on the clock edge that accepts a request, so
// one request per cycle is sustained unless the result register is stalled
// the result lands in an output register; a new request is taken whenever that
// register is empty or is being drained in the same cycle
// reset clears the sequencer to idle with scl low and sda driven low,
// ticks_per_unit to 1 and ack_timeout to 250
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_defines.svh"

module i2c_master_bit_sequencer import i2cbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] cmd, [10:3] tx_byte, [11] send_ack, [12] sda_in, [15:13] zero
  input  logic [TDATA_W-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rx_byte, [13] ack_fail, [15:14] zero
  output logic [TDATA_W-1:0]  m_axis_tdata,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_addr_i,
  input  logic [15:0]         cfg_wdata_i
);

  // configuration registers
  cfg_t       cfg_q;

  // sequencer state
  seq_state_t state_q, state_d;
  logic       done;

  // result register
  logic               out_valid_q;
  logic [TDATA_W-1:0] out_data_q, out_data_d;

  item_t item;
  logic  accept;

  // unpack the request
  assign item.cmd      = s_axis_tdata[2:0];
  assign item.tx_byte  = s_axis_tdata[10:3];
  assign item.send_ack = s_axis_tdata[11];
  assign item.sda_in   = s_axis_tdata[12];

  // take a request while the result slot is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_unit <= TICKS_RESET;
      cfg_q.ack_timeout    <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_TICKS_PER_UNIT: cfg_q.ticks_per_unit <= cfg_wdata_i;
        REG_ACK_TIMEOUT:    cfg_q.ack_timeout    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // one tick of the line sequencer
  i2cbs_step u_step (
    .cur_i  (state_q),
    .item_i (item),
    .cfg_i  (cfg_q),
    .nxt_o  (state_d),
    .done_o (done)
  );

  // pack the result from the state after this tick
  assign out_data_d = {
    2'b00,
    state_d.ack_flag,
    state_d.rx,
    done,
    (state_d.cmd != CMD_NONE),
    state_d.drv,
    state_d.sda,
    state_d.scl
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_RESET;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a finished command never reports busy
  `I2CBS_ASSERT(a_done_not_busy, m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]), "done with busy")

  // an empty result slot must never block requests
  `I2CBS_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "ready low with empty output")

  // the delay counter only runs inside a command
  `I2CBS_ASSERT(a_idle_no_delay, (state_q.cmd == CMD_NONE) |-> (state_q.delay == '0), "delay while idle")

  // no result shows while reset is held
  `I2CBS_ASSERT_ALWAYS(a_reset_no_valid, !rst_ni |-> !m_axis_tvalid, "valid during reset")

endmodule
